// ===== hdl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types, constants and helpers of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int N_W         = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 10;
  localparam int SLOT_W      = 6;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 7;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 7'd40;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

  localparam logic REG_TABLE_SIZE = 1'b0;

  typedef struct packed {
    logic             is_search;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
    logic [N_W-1:0]   n;
  } req_t;

  function automatic logic [N_W-1:0] live_size(input logic [CFG_W-1:0] ts);
    logic [N_W-1:0] n;
    if (ts == '0) begin
      n = N_W'(1);
    end else if (int'(ts) > TABLE_DEPTH) begin
      n = N_W'(TABLE_DEPTH);
    end else begin
      n = N_W'(ts);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lpht_front.sv =====
// ----------------------------------------------------------------------------
// lpht_front
// Accepts requests and computes the home slot, key mod size, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic                        req_type,
  input  wire logic [lpht_pkg::KEY_W-1:0]  key,
  input  wire logic [lpht_pkg::CFG_W-1:0]  table_size,
  output logic                             q_push,
  input  wire logic                        q_full,
  output lpht_pkg::req_t                   q_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PUSH
  } state_t;

  localparam int STEP_W = $clog2(lpht_pkg::KEY_W);

  state_t                      state;
  logic                        is_search;
  logic [lpht_pkg::KEY_W-1:0]  key_q;
  logic [lpht_pkg::KEY_W-1:0]  kshift;
  logic [lpht_pkg::N_W-1:0]    n;
  logic [lpht_pkg::N_W-1:0]    rem;
  logic [STEP_W-1:0]           step;
  logic [lpht_pkg::N_W:0]      sh;
  logic [lpht_pkg::N_W-1:0]    rem_next;

  always_comb begin
    sh = {rem, kshift[lpht_pkg::KEY_W-1]};
    if (sh >= {1'b0, n}) begin
      rem_next = lpht_pkg::N_W'(sh - {1'b0, n});
    end else begin
      rem_next = lpht_pkg::N_W'(sh);
    end
  end

  assign full   = (state != S_IDLE);
  assign q_push = (state == S_PUSH);
  assign q_data = '{is_search: is_search, key: key_q,
                    home: lpht_pkg::IDX_W'(rem), n: n};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            is_search <= req_type;
            key_q     <= key;
            kshift    <= key;
            n         <= lpht_pkg::live_size(table_size);
            rem       <= '0;
            step      <= '0;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= rem_next;
          kshift <= {kshift[lpht_pkg::KEY_W-2:0], 1'b0};
          step   <= step + STEP_W'(1);
          if (step == STEP_W'(lpht_pkg::KEY_W - 1)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_rem_below_n: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV || state == S_PUSH) |-> (rem < n))
    else $error("front: remainder not below modulus");
  a_n_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (n != '0))
    else $error("front: zero modulus");
  a_push_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) && !$past(state == S_PUSH) |-> $past(state == S_DIV))
    else $error("front: push without divide");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpht_queue.sv =====
// ----------------------------------------------------------------------------
// lpht_queue
// Two-entry request queue between the front and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire lpht_pkg::req_t wr_data,
  output logic        full,
  input  wire logic   rd_en,
  output logic        valid,
  output lpht_pkg::req_t rd_data
);

  lpht_pkg::req_t entry [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_wr;
  logic           do_rd;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_data = entry[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

`ifndef SYNTH
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue: pointers disagree with count");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue: count overrun");
  a_one_ptr: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("queue: single entry pointers equal");
`endif

endmodule

`default_nettype wire

// ===== hdl/lpht_back.sv =====
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: walks the slots from the home slot and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_valid,
  input  wire lpht_pkg::req_t                 q_data,
  output logic                                q_pop,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [lpht_pkg::STATUS_W-1:0]       status,
  output logic [lpht_pkg::SLOT_W-1:0]         slot
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_t;

  localparam int IW = lpht_pkg::IDX_W;
  localparam int NW = lpht_pkg::N_W;

  state_t                           state;
  lpht_pkg::req_t                   cur;
  logic [IW-1:0]                    ipos;
  logic [IW-1:0]                    cnt;
  logic                             cvalid;
  logic [lpht_pkg::KEY_W-1:0]       rd_key;
  logic                             rd_used;
  logic [IW-1:0]                    rd_pos;
  logic [lpht_pkg::TABLE_DEPTH-1:0] slot_used;
  logic [lpht_pkg::KEY_W-1:0]       slot_key [lpht_pkg::TABLE_DEPTH];
  logic                             res_valid;
  logic [lpht_pkg::STATUS_W-1:0]    fin_status;
  logic [lpht_pkg::SLOT_W-1:0]      fin_slot;

  logic                             hit_free;
  logic                             hit_key;
  logic                             last;
  logic                             done;
  logic                             mem_we;
  logic [NW-1:0]                    ipos_inc;
  logic [IW-1:0]                    ipos_next;
  logic [lpht_pkg::STATUS_W-1:0]    done_status;
  logic [lpht_pkg::SLOT_W-1:0]      done_slot;

  always_comb begin
    hit_free  = cvalid && !rd_used;
    hit_key   = cvalid && rd_used && cur.is_search && (rd_key == cur.key);
    last      = cvalid && ((NW'(cnt) + NW'(1)) == cur.n);
    done      = hit_free || hit_key || last;
    mem_we    = (state == S_PROBE) && hit_free && !cur.is_search;
    ipos_inc  = NW'(ipos) + NW'(1);
    ipos_next = (ipos_inc == cur.n) ? '0 : IW'(ipos_inc);
    priority if (hit_free) begin
      done_status = cur.is_search ? lpht_pkg::ST_NOT_FOUND : lpht_pkg::ST_INSERTED;
      done_slot   = cur.is_search ? '0 : lpht_pkg::SLOT_W'(rd_pos);
    end else if (hit_key) begin
      done_status = lpht_pkg::ST_FOUND;
      done_slot   = lpht_pkg::SLOT_W'(rd_pos);
    end else begin
      done_status = cur.is_search ? lpht_pkg::ST_NOT_FOUND : lpht_pkg::ST_OVERFLOW;
      done_slot   = '0;
    end
  end

  assign q_pop  = (state == S_IDLE) && q_valid;
  assign empty  = !res_valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_key[rd_pos] <= cur.key;
    end
    rd_key <= slot_key[ipos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cvalid    <= 1'b0;
      res_valid <= 1'b0;
      slot_used <= '0;
    end else begin
      if (state == S_FINISH && (!res_valid || pop)) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur    <= q_data;
            ipos   <= q_data.home;
            cnt    <= '0;
            cvalid <= 1'b0;
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          rd_used <= slot_used[ipos];
          rd_pos  <= ipos;
          ipos    <= ipos_next;
          cvalid  <= !done;
          if (cvalid) begin
            cnt <= cnt + IW'(1);
          end
          if (done) begin
            if (mem_we) begin
              slot_used[rd_pos] <= 1'b1;
            end
            fin_status <= done_status;
            fin_slot   <= done_slot;
            state      <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!res_valid || pop) begin
            status    <= fin_status;
            slot      <= fin_slot;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_zero_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == lpht_pkg::ST_NOT_FOUND || status == lpht_pkg::ST_OVERFLOW)
    |-> (slot == '0))
    else $error("back: nonzero slot on miss");
  a_insert_marks: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> slot_used[$past(rd_pos)])
    else $error("back: insert left slot unused");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (NW'(cnt) < cur.n))
    else $error("back: probe count past size");
  a_ipos_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (NW'(ipos) < cur.n))
    else $error("back: probe position past size");
`endif

endmodule

`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over up to 64 slots.
//
// Requests enter through a queue-style port: a beat is taken when push is
// high and full is low; req_type selects insert or search of key. Results
// leave the same way: status and slot are valid while empty is low and the
// beat is taken when pop is high. One result per request, in order.
// table_size is written over the APB-style port at byte addresses 0 to 3.
// The front takes a request, computes key mod size (one key bit a cycle)
// and hands it to a two-entry queue; it takes no new request until then.
// The probe engine reads one slot a cycle from the key memory and takes
// the next request from the queue only after the last one's result has
// moved to the output registers.
// The engine keeps running while a result waits to be popped, up to one
// finished result held inside; the front keeps accepting into the queue.
// Reset clears all used marks at once, empties the queues and sets
// table_size to 40; stored keys need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               req_type,
  input  wire logic [lpht_pkg::KEY_W-1:0]         key,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [lpht_pkg::STATUS_W-1:0]           status,
  output logic [lpht_pkg::SLOT_W-1:0]             slot,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [lpht_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [lpht_pkg::DATA_W-1:0]        pwdata,
  output logic [lpht_pkg::DATA_W-1:0]             prdata,
  output logic                                    pready
);

  logic [lpht_pkg::CFG_W-1:0] table_size;
  logic                       q_push;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  lpht_pkg::req_t             q_wr_data;
  lpht_pkg::req_t             q_rd_data;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lpht_pkg::ADDR_W-1] == lpht_pkg::REG_TABLE_SIZE);
  assign prdata  = reg_sel ? lpht_pkg::DATA_W'(table_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= lpht_pkg::TABLE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      table_size <= pwdata[lpht_pkg::CFG_W-1:0];
    end
  end

  lpht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .key        (key),
    .table_size (table_size),
    .q_push     (q_push),
    .q_full     (q_full),
    .q_data     (q_wr_data)
  );

  lpht_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  lpht_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .status  (status),
    .slot    (slot)
  );

endmodule

`default_nettype wire
